@@ hw/rtl/annexb_nal_unit_splitter_macros.svh @@
// Assertion helpers shared by the RTL of the NAL unit splitter.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// Checks that prop holds at every rising edge of clk_i outside reset.
`define NS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define NS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/nalsplit_pkg.sv @@
package nalsplit_pkg;

  localparam int unsigned LengthBitsDefault = 24;
  localparam int unsigned OffsetBitsDefault = 32;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LimitW   = 24;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OffsetW  = 32;
  localparam int unsigned PrefixW  = 3;
  localparam int unsigned PayloadW = 24;
  localparam int unsigned WindowW  = 24;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OffLsb  = 0;
  localparam int unsigned PreLsb  = OffLsb + OffsetW;
  localparam int unsigned LenLsb  = PreLsb + PrefixW;
  localparam int unsigned FzBit   = LenLsb + PayloadW;
  localparam int unsigned RefLsb  = FzBit + 1;
  localparam int unsigned TypeLsb = RefLsb + 2;
  localparam int unsigned OutUsedW = TypeLsb + 5;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(100000);

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_START = 2'd1;
  localparam logic [StatusW-1:0] STATUS_OVERSIZE  = 2'd2;

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_UNIT = 2'd1;
  localparam logic [1:0] PH_DROP = 2'd2;

  localparam logic [PrefixW-1:0] PREFIX_SHORT = 3'd3;
  localparam logic [PrefixW-1:0] PREFIX_LONG  = 3'd4;

  localparam logic [ByteW-1:0] HdrForbiddenMask = 8'h80;
  localparam logic [ByteW-1:0] HdrRefIdcMask    = 8'h60;
  localparam logic [ByteW-1:0] HdrTypeMask      = 8'h1f;

endpackage

@@ hw/rtl/annexb_nal_unit_splitter.sv @@
// Channel         | Direction | Payload
// s_axis          | in        | tdata[7:0] stream byte, tlast last byte of the stream
// m_axis          | out       | tuser[1:0] status, tdata[71:0] unit descriptor
// nal_size_limit  | in        | 24-bit payload limit, written when we is high
//
// Each accepted byte passes through the input register, then through the start-code
// compare and counter update into the result register.
// One byte is accepted every cycle while the result register is free or being taken.
// A stall on m_axis holds the result and backs up into s_axis through the input stage.
// Reset clears the stream state and sets the limit to 100000.
`include "annexb_nal_unit_splitter_macros.svh"

module annexb_nal_unit_splitter #(
  parameter int unsigned LENGTH_BITS = nalsplit_pkg::LengthBitsDefault,
  parameter int unsigned OFFSET_BITS = nalsplit_pkg::OffsetBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               nal_size_limit_we_i,
  input  logic [nalsplit_pkg::LimitW-1:0]    nal_size_limit_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: data_byte.
  input  logic [nalsplit_pkg::ByteW-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: unit_offset, prefix_length, payload_length, forbidden_zero, ref_idc,
  // unit_type, zero fill.
  output logic [nalsplit_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser: status.
  output logic [nalsplit_pkg::StatusW-1:0]   m_axis_tuser_o
);
  import nalsplit_pkg::*;

  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned OB = OFFSET_BITS;
  localparam logic [LB-1:0] LenMax = {LB{1'b1}};

  logic [LimitW-1:0]  limit_q;

  logic               in_valid_q;
  logic [ByteW-1:0]   in_byte_q;
  logic               in_end_q;

  logic [1:0]         phase_q, phase_d;
  logic [WindowW-1:0] window_q, window_d;
  logic [OB-1:0]      pos_q, pos_d;
  logic [OB-1:0]      offset_q, offset_d;
  logic [PrefixW-1:0] prefix_q, prefix_d;
  logic [LB-1:0]      count_q, count_d;
  logic [ByteW-1:0]   header_q, header_d;

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [OB-1:0]      out_offset_q, out_offset_d;
  logic [PrefixW-1:0] out_prefix_q, out_prefix_d;
  logic [LB-1:0]      out_len_q, out_len_d;
  logic [ByteW-1:0]   out_header_q, out_header_d;

  logic               advance;
  logic               fire;
  logic               emit;
  logic [63:0]        len_wide;
  logic [63:0]        off_wide;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (nal_size_limit_we_i) begin
      limit_q <= nal_size_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  always_comb begin
    logic [WindowW-1:0] win;
    logic [LB-1:0]      len;
    logic [LB-1:0]      cnt_sat;
    logic [PrefixW-1:0] plen;
    logic [ByteW-1:0]   hdr;
    logic               do_open;
    logic               bad;
    logic               unit_done;

    win       = {window_q[WindowW-ByteW-1:0], in_byte_q};
    len       = '0;
    cnt_sat   = (count_q == LenMax) ? LenMax : count_q + LB'(1);
    plen      = PREFIX_SHORT;
    hdr       = header_q;
    do_open   = 1'b0;
    bad       = 1'b0;
    unit_done = 1'b0;

    phase_d  = phase_q;
    window_d = window_q;
    pos_d    = pos_q;
    offset_d = offset_q;
    prefix_d = prefix_q;
    count_d  = count_q;
    header_d = header_q;

    if (fire) begin
      window_d = win;
      pos_d    = pos_q + OB'(1);
      unique case (phase_q)
        PH_LEAD: begin
          if (count_q < LB'(2)) begin
            count_d = count_q + LB'(1);
            bad     = in_end_q;
          end else if (count_q == LB'(2) && win == WindowW'(1)) begin
            do_open = 1'b1;
            plen    = PREFIX_SHORT;
          end else if (count_q == LB'(2) && win == '0) begin
            count_d = LB'(3);
            bad     = in_end_q;
          end else if (count_q >= LB'(3) && win == WindowW'(1)) begin
            do_open = 1'b1;
            plen    = PREFIX_LONG;
          end else begin
            bad     = 1'b1;
            phase_d = PH_DROP;
          end
        end
        PH_UNIT: begin
          if (in_byte_q == ByteW'(1) && window_q[15:0] == '0) begin
            plen      = (window_q[23:16] == '0) ? PREFIX_LONG : PREFIX_SHORT;
            len       = (count_q == LenMax) ? LenMax
                      : LB'(count_q + LB'(1) - LB'(plen));
            unit_done = 1'b1;
            do_open   = 1'b1;
          end else begin
            if (count_q == '0) begin
              header_d = in_byte_q;
              hdr      = in_byte_q;
            end
            count_d   = cnt_sat;
            len       = cnt_sat;
            unit_done = in_end_q;
          end
        end
        PH_DROP: begin
        end
        default: begin
        end
      endcase

      if (do_open) begin
        phase_d  = PH_UNIT;
        prefix_d = plen;
        offset_d = pos_q - OB'(plen - PrefixW'(1));
        count_d  = '0;
        header_d = '0;
      end

      if (in_end_q) begin
        phase_d  = PH_LEAD;
        window_d = '1;
        pos_d    = '0;
        offset_d = '0;
        prefix_d = PREFIX_SHORT;
        count_d  = '0;
        header_d = '0;
      end
    end

    emit         = bad || unit_done;
    out_status_d = STATUS_BAD_START;
    out_offset_d = '0;
    out_prefix_d = '0;
    out_len_d    = '0;
    out_header_d = '0;
    if (unit_done) begin
      out_status_d = (64'(len) > 64'(limit_q)) ? STATUS_OVERSIZE : STATUS_OK;
      out_offset_d = offset_q;
      out_prefix_d = prefix_q;
      out_len_d    = len;
      out_header_d = (len == '0) ? '0 : hdr;
    end

    if (fire) begin
      out_valid_d = emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      window_q    <= '1;
      pos_q       <= '0;
      offset_q    <= '0;
      prefix_q    <= PREFIX_SHORT;
      count_q     <= '0;
      header_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      window_q    <= window_d;
      pos_q       <= pos_d;
      offset_q    <= offset_d;
      prefix_q    <= prefix_d;
      count_q     <= count_d;
      header_q    <= header_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_status_q <= out_status_d;
      out_offset_q <= out_offset_d;
      out_prefix_q <= out_prefix_d;
      out_len_q    <= out_len_d;
      out_header_q <= out_header_d;
    end
  end

  assign len_wide = 64'(out_len_q);
  assign off_wide = 64'(out_offset_q);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {
    (OutDataW - OutUsedW)'(0),
    out_header_q[4:0] & HdrTypeMask[4:0],
    2'((out_header_q & HdrRefIdcMask) >> 5),
    1'((out_header_q & HdrForbiddenMask) >> 7),
    len_wide[PayloadW-1:0],
    out_prefix_q,
    off_wide[OffsetW-1:0]
  };

  `NS_ASSERT(bad_start_fields_zero,
    !(m_axis_tvalid_o && m_axis_tuser_o == STATUS_BAD_START) || m_axis_tdata_o == '0,
    "bad-start result carries nonzero fields")
  `NS_ASSERT(unit_prefix_valid,
    !(m_axis_tvalid_o && m_axis_tuser_o != STATUS_BAD_START) ||
      m_axis_tdata_o[LenLsb-1:PreLsb] == PREFIX_SHORT ||
      m_axis_tdata_o[LenLsb-1:PreLsb] == PREFIX_LONG,
    "unit result with a prefix length other than three or four")
  `NS_ASSERT(empty_unit_no_header,
    !(m_axis_tvalid_o && m_axis_tdata_o[FzBit-1:LenLsb] == '0) ||
      m_axis_tdata_o[OutUsedW-1:FzBit] == '0,
    "empty unit reports header fields")
  `NS_ASSERT_NEXT(end_rearms, fire && in_end_q,
    phase_q == PH_LEAD && pos_q == '0 && count_q == '0,
    "stream state not cleared after the last byte")

endmodule

@@ tb/sv/annexb_nal_unit_splitter_tb.sv @@
module annexb_nal_unit_splitter_tb;
  import nalsplit_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [OffsetW-1:0]  offset;
    logic [PrefixW-1:0]  prefix;
    logic [PayloadW-1:0] length;
    logic                forbidden_zero;
    logic [1:0]          ref_idc;
    logic [4:0]          unit_type;
  } nal_report_t;

  localparam logic [PayloadW-1:0] LenSat    = '1;
  localparam logic [WindowW-1:0]  CodeShort = 24'h000001;
  localparam logic [WindowW-1:0]  CodeZeros = 24'h000000;
  localparam int unsigned         HoldCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                limit_we = 1'b0;
  logic [LimitW-1:0]   limit_val = '0;
  logic                s_valid = 1'b0;
  logic [ByteW-1:0]    s_data = '0;
  logic                s_last = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [StatusW-1:0]  m_user;

  annexb_nal_unit_splitter i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .nal_size_limit_we_i (limit_we),
    .nal_size_limit_i    (limit_val),
    .s_axis_tvalid_i     (s_valid),
    .s_axis_tready_o     (s_ready),
    .s_axis_tdata_i      (s_data),
    .s_axis_tlast_i      (s_last),
    .m_axis_tvalid_o     (m_valid),
    .m_axis_tready_i     (m_ready),
    .m_axis_tdata_o      (m_data),
    .m_axis_tuser_o      (m_user)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Parser state as predicted from the accepted bytes.
  logic [1:0]          p_phase;
  logic [WindowW-1:0]  p_window;
  logic [OffsetW-1:0]  p_position;
  logic [OffsetW-1:0]  p_offset;
  logic [PrefixW-1:0]  p_prefix;
  logic [PayloadW-1:0] p_count;
  logic [ByteW-1:0]    p_header;
  logic [LimitW-1:0]   p_limit;

  nal_report_t expected_units[$];
  logic [ByteW-1:0] stream_buf[$];

  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 78;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned live_items = 0;
  int unsigned streams_sent = 0;
  int unsigned limit_writes = 0;

  task automatic clear_stream();
    p_phase    = PH_LEAD;
    p_window   = '1;
    p_position = '0;
    p_offset   = '0;
    p_prefix   = PREFIX_SHORT;
    p_count    = '0;
    p_header   = '0;
  endtask

  task automatic open_unit(input logic [PrefixW-1:0] plen, input logic [OffsetW-1:0] pos);
    p_phase  = PH_UNIT;
    p_prefix = plen;
    p_offset = pos - OffsetW'(plen - 3'd1);
    p_count  = '0;
    p_header = '0;
  endtask

  function automatic nal_report_t bad_start_report();
    nal_report_t r;
    r = '0;
    r.status = STATUS_BAD_START;
    return r;
  endfunction

  function automatic nal_report_t unit_report(input logic [PayloadW-1:0] len);
    nal_report_t r;
    logic [ByteW-1:0] h;
    h = (len == '0) ? '0 : p_header;
    r.status         = (len > p_limit) ? STATUS_OVERSIZE : STATUS_OK;
    r.offset         = p_offset;
    r.prefix         = p_prefix;
    r.length         = len;
    r.forbidden_zero = |(h & HdrForbiddenMask);
    r.ref_idc        = 2'((h & HdrRefIdcMask) >> 5);
    r.unit_type      = 5'(h & HdrTypeMask);
    return r;
  endfunction

  task automatic track_byte(input logic [ByteW-1:0] b, input logic last);
    logic [OffsetW-1:0]  pos;
    logic [WindowW-1:0]  old;
    logic [WindowW-1:0]  win;
    logic [PayloadW-1:0] c;
    logic [PrefixW-1:0]  plen;
    logic [PayloadW-1:0] len;
    pos = p_position;
    old = p_window;
    win = {old[15:0], b};
    c = p_count;
    p_window = win;
    p_position = OffsetW'(pos + 1);
    bytes_sent++;
    if (p_phase != PH_DROP) live_items++;
    case (p_phase)
      PH_LEAD: begin
        if (c < 2) begin
          p_count = PayloadW'(c + 1);
          if (last) expected_units.push_back(bad_start_report());
        end else if (c == 2 && win == CodeShort) begin
          open_unit(PREFIX_SHORT, pos);
        end else if (c == 2 && win == CodeZeros) begin
          p_count = PayloadW'(3);
          if (last) expected_units.push_back(bad_start_report());
        end else if (c >= 3 && win == CodeShort) begin
          open_unit(PREFIX_LONG, pos);
        end else begin
          expected_units.push_back(bad_start_report());
          p_phase = PH_DROP;
        end
      end
      PH_UNIT: begin
        if (b == 8'h01 && old[15:0] == 16'h0000) begin
          plen = (old[23:16] == 8'h00) ? PREFIX_LONG : PREFIX_SHORT;
          len = (c == LenSat) ? LenSat : PayloadW'(c + 1 - plen);
          expected_units.push_back(unit_report(len));
          open_unit(plen, pos);
        end else begin
          if (c == '0) p_header = b;
          p_count = (c < LenSat) ? PayloadW'(c + 1) : LenSat;
          if (last) expected_units.push_back(unit_report(p_count));
        end
      end
      default: begin
      end
    endcase
    if (last) clear_stream();
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    track_byte(b, last);
  endtask

  task automatic send_stream();
    foreach (stream_buf[i]) push_byte(stream_buf[i], i == stream_buf.size() - 1);
    streams_sent++;
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    wait_idle();
    limit_we  <= 1'b1;
    limit_val <= value;
    @(posedge clk_i);
    p_limit = value;
    limit_writes++;
    limit_we <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] payload_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 30) return 8'h01;
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic add_start_code();
    if ($urandom_range(1) == 1) stream_buf.push_back(8'h00);
    stream_buf.push_back(8'h00);
    stream_buf.push_back(8'h00);
    stream_buf.push_back(8'h01);
  endtask

  task automatic build_wellformed();
    int unsigned units;
    int unsigned len;
    stream_buf.delete();
    add_start_code();
    units = $urandom_range(1, 5);
    for (int unsigned u = 0; u < units; u++) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      repeat (len) stream_buf.push_back(payload_byte());
      if (u != units - 1) add_start_code();
    end
    if ($urandom_range(5) == 0) add_start_code();
  endtask

  task automatic build_noise();
    stream_buf.delete();
    repeat ($urandom_range(1, 8)) stream_buf.push_back(payload_byte());
  endtask

  task automatic build_broken();
    stream_buf.delete();
    stream_buf.push_back(8'h00);
    stream_buf.push_back(8'h00);
    case ($urandom_range(2))
      0: begin
        stream_buf.push_back(8'h00);
        stream_buf.push_back(ByteW'($urandom_range(2, 255)));
      end
      1: begin
        stream_buf.push_back(ByteW'($urandom_range(2, 255)));
      end
      default: begin
        stream_buf.push_back(8'h00);
        stream_buf.push_back(8'h00);
      end
    endcase
    repeat ($urandom_range(0, 6)) stream_buf.push_back(payload_byte());
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    nal_report_t got;
    nal_report_t want;
    if (rst_ni && m_valid && m_ready) begin
      got.status         = m_user;
      got.offset         = m_data[OffLsb +: OffsetW];
      got.prefix         = m_data[PreLsb +: PrefixW];
      got.length         = m_data[LenLsb +: PayloadW];
      got.forbidden_zero = m_data[FzBit];
      got.ref_idc        = m_data[RefLsb +: 2];
      got.unit_type      = m_data[TypeLsb +: 5];
      results_seen++;
      if (expected_units.size() == 0) begin
        flag_mismatch("unexpected result, status", 32'(got.status), 32'h0);
      end else begin
        want = expected_units.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.offset !== want.offset)
          flag_mismatch("unit_offset", got.offset, want.offset);
        if (got.prefix !== want.prefix)
          flag_mismatch("prefix_length", 32'(got.prefix), 32'(want.prefix));
        if (got.length !== want.length)
          flag_mismatch("payload_length", 32'(got.length), 32'(want.length));
        if (got.forbidden_zero !== want.forbidden_zero)
          flag_mismatch("forbidden_zero", 32'(got.forbidden_zero), 32'(want.forbidden_zero));
        if (got.ref_idc !== want.ref_idc)
          flag_mismatch("ref_idc", 32'(got.ref_idc), 32'(want.ref_idc));
        if (got.unit_type !== want.unit_type)
          flag_mismatch("unit_type", 32'(got.unit_type), 32'(want.unit_type));
      end
    end
  end

  always @(posedge clk_i) begin : drive_receiver
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic test_bad_start();
    stream_buf = '{8'h01, 8'h02, 8'h03};
    send_stream();
    stream_buf = '{8'h00, 8'h00};
    send_stream();
  endtask

  task automatic test_unit_framing();
    stream_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00, 8'h01,
                   8'h00, 8'h00, 8'h01, 8'h00, 8'h12, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h7f, 8'h00, 8'h00, 8'h01};
    send_stream();
  endtask

  task automatic test_random_streams(input logic [LimitW-1:0] limit, input int unsigned tx,
                                     input int unsigned rx, input int unsigned count);
    int unsigned target;
    int unsigned pick;
    write_limit(limit);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    target = live_items + count;
    while (live_items < target) begin
      pick = $urandom_range(99);
      if (pick < 75) build_wellformed();
      else if (pick < 87) build_noise();
      else build_broken();
      send_stream();
    end
  endtask

  // The receiver stops for a long stretch while whole streams keep coming.
  task automatic test_backpressure();
    int unsigned target;
    write_limit(LimitReset);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    target = live_items + 60;
    hold_requests++;
    while (live_items < target) begin
      build_wellformed();
      send_stream();
    end
  endtask

  initial begin
    p_limit = LimitReset;
    clear_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_start();
    test_unit_framing();
    test_random_streams(LimitW'(1), 30, 78, 150);
    test_random_streams(LimitW'($urandom_range(2, 12)), 30, 78, 100);
    test_random_streams(LimitW'(0), 78, 30, 100);
    test_random_streams('1, 78, 30, 100);
    test_random_streams(LimitW'($urandom_range(2, 12)), 0, 0, 100);
    test_backpressure();
    wait_idle();
    $display("Sent %0d bytes (%0d parsed) in %0d streams under %0d limit settings.",
             bytes_sent, live_items, streams_sent, limit_writes);
    $display("Checked %0d unit reports, with one long output stall.", results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
